### design/rets_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rets_pkg
// Shared codes and widths of the tick scheduler.
// ----------------------------------------------------------------------------
package rets_pkg;

   localparam int PARAM_W = 16;
   localparam int SEG_W   = 24;
   localparam int CHOICE_W = 6;
   localparam int COUNT_W  = 5;
   localparam int TASK_CAP = 16;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_TASK  = 2'd1;
   localparam logic [1:0] KIND_IDLE  = 2'd2;
   localparam logic [1:0] KIND_STATS = 2'd3;

   localparam logic [1:0] REASON_LOST    = 2'd0;
   localparam logic [1:0] REASON_FINISH  = 2'd1;
   localparam logic [1:0] REASON_PREEMPT = 2'd2;

   localparam logic [CHOICE_W-1:0] CHOICE_NONE = 6'h3F;
   localparam logic [CHOICE_W-1:0] CHOICE_IDLE = 6'h3E;

   localparam logic [PARAM_W-1:0] CNT_MAX = '1;
   localparam logic [SEG_W-1:0]   SEG_MAX = '1;

   localparam logic CSR_POLICY     = 1'b0;
   localparam logic CSR_TASK_COUNT = 1'b1;

endpackage
`default_nettype wire

### design/rets_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rets_mod_unit
// Restoring remainder unit: tells whether the time is a multiple of a period,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rets_mod_unit
   import rets_pkg::*;
#(
   parameter int TIME_BITS = 24
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [TIME_BITS-1:0]  dividend,
   input  wire [PARAM_W-1:0]    divisor,
   output logic                 done,
   output logic                 rem_zero
);

   localparam int CNT_W = $clog2(TIME_BITS + 1);

   logic [TIME_BITS-1:0] shift_ff, shift_in;
   logic [PARAM_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [PARAM_W:0]     trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[TIME_BITS-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CNT_W'(TIME_BITS);
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[TIME_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = PARAM_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[PARAM_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule
`default_nettype wire

### design/rm_edf_tick_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rm_edf_tick_scheduler_top
// Periodic task scheduler, rate monotonic or earliest deadline first.
// ----------------------------------------------------------------------------
// The status of a load appears on the next cycle. A tick reads every active
// task entry in turn from the task memory, which has one read and one write
// port, runs its release test through the remainder unit, which retires one
// time bit per cycle, and writes the entry back. A finish gives at most one
// result per cycle. Results are shown for one cycle under rsp_valid and
// cannot be held off; busy can already be low when the last result of an
// item is shown.
// ----------------------------------------------------------------------------
module rm_edf_tick_scheduler_top
   import rets_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 24
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire [1:0]            req_operation,
   input  wire [3:0]            req_task_index,
   input  wire [PARAM_W-1:0]    req_period,
   input  wire [PARAM_W-1:0]    req_relative_deadline,
   input  wire [PARAM_W-1:0]    req_burst,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_kind,
   output logic [3:0]           rsp_which_task,
   output logic [SEG_W-1:0]     rsp_run_length,
   output logic [1:0]           rsp_end_reason,
   output logic                 rsp_load_ok,
   output logic [PARAM_W-1:0]   rsp_lost_total,
   output logic [PARAM_W-1:0]   rsp_complete_total,
   output logic                 rsp_killed_total,
   output logic                 rsp_last,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [0:0]            csr_index,
   input  wire [COUNT_W-1:0]    csr_data
);

   localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int KW  = ((TIME_BITS > PARAM_W) ? TIME_BITS : PARAM_W) + 1;
   localparam int CAP = (MAX_TASKS < TASK_CAP) ? MAX_TASKS : TASK_CAP;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_T_RD  = 4'd1;
   localparam logic [3:0] S_T_DST = 4'd2;
   localparam logic [3:0] S_T_DIV = 4'd3;
   localparam logic [3:0] S_T_WR  = 4'd4;
   localparam logic [3:0] S_T_CRD = 4'd5;
   localparam logic [3:0] S_T_CWR = 4'd6;
   localparam logic [3:0] S_T_PRD = 4'd7;
   localparam logic [3:0] S_T_REP = 4'd8;
   localparam logic [3:0] S_F_RD  = 4'd9;
   localparam logic [3:0] S_F_EM  = 4'd10;

   typedef struct packed {
      logic [PARAM_W-1:0]   period;
      logic [PARAM_W-1:0]   deadline;
      logic [PARAM_W-1:0]   burst;
      logic [PARAM_W-1:0]   remaining;
      logic [TIME_BITS-1:0] release_t;
      logic [PARAM_W-1:0]   lost;
      logic [PARAM_W-1:0]   complete;
   } entry_type;

   // Task memory with a registered read port.
   entry_type      mem [MAX_TASKS];
   entry_type      rd_data_ff;
   logic           rd_valid_ff;
   logic [MAX_TASKS-1:0] valid_ff, valid_in;
   logic           mem_we, mem_re;
   logic [IW-1:0]  mem_wa, mem_ra;
   entry_type      mem_wd;
   entry_type      e;

   logic [3:0]            state_ff, state_in;
   logic                  policy_ff, policy_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    n_act;
   logic [COUNT_W-1:0]    i_ff, i_in;
   logic [CHOICE_W-1:0]   choice_ff, choice_in;
   logic [CHOICE_W-1:0]   prev_ff, prev_in;
   logic [KW-1:0]         best_ff, best_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [SEG_W-1:0]      seg_ff, seg_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [3:0]            rsp_task_ff, rsp_task_in;
   logic [SEG_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [1:0]            rsp_reason_ff, rsp_reason_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [PARAM_W-1:0]    rsp_lost_ff, rsp_lost_in;
   logic [PARAM_W-1:0]    rsp_comp_ff, rsp_comp_in;
   logic                  rsp_killed_ff, rsp_killed_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  div_start, div_done, div_rem_zero;

   // Per-entry update terms of the tick pass, with the load check and prev test.
   logic                  released, hit, load_ok, prev_is_task;
   logic [PARAM_W-1:0]    rw1, rw2, lost2, dec;
   logic [TIME_BITS-1:0]  rt1;
   logic [KW-1:0]         dsum, key;

   rets_mod_unit #(
      .TIME_BITS (TIME_BITS)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (time_ff),
      .divisor  (e.period),
      .done     (div_done),
      .rem_zero (div_rem_zero)
   );

   assign e = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      if (count_ff > COUNT_W'(CAP)) begin
         n_act = COUNT_W'(CAP);
      end else begin
         n_act = count_ff;
      end
   end

   always_comb begin
      released = (e.period != '0) && div_rem_zero;
      rw1      = released ? e.burst : e.remaining;
      rt1      = released ? time_ff : e.release_t;
      dsum     = KW'(rt1) + KW'(e.deadline);
      hit      = (dsum[TIME_BITS-1:0] == time_ff);
      rw2      = (hit && rw1 != '0) ? '0 : rw1;
      lost2    = (hit && rw1 != '0 && e.lost != CNT_MAX) ? e.lost + 1'b1 : e.lost;
      key      = policy_ff ? dsum : KW'(e.period);
      dec      = e.remaining - 1'b1;
      load_ok  = (32'(req_task_index) < MAX_TASKS) && (req_period != '0)
                 && (req_burst <= req_relative_deadline)
                 && (req_relative_deadline <= req_period);
      prev_is_task = (prev_ff != CHOICE_NONE) && (prev_ff != CHOICE_IDLE);
   end

   always_comb begin
      state_in  = state_ff;
      policy_in = policy_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      choice_in = choice_ff;
      prev_in   = prev_ff;
      best_in   = best_ff;
      time_in   = time_ff;
      seg_in    = seg_ff;
      valid_in  = valid_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wa    = IW'(i_ff);
      mem_ra    = IW'(i_ff);
      mem_wd    = e;
      div_start = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_LOAD;
      rsp_task_in   = '0;
      rsp_len_in    = '0;
      rsp_reason_in = REASON_LOST;
      rsp_ok_in     = 1'b0;
      rsp_lost_in   = '0;
      rsp_comp_in   = '0;
      rsp_killed_in = 1'b0;
      rsp_last_in   = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLICY:     policy_in = csr_data[0];
            CSR_TASK_COUNT: count_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_LOAD: begin
                     if (load_ok) begin
                        mem_we    = 1'b1;
                        mem_wa    = IW'(req_task_index);
                        mem_wd    = '{period: req_period,
                                      deadline: req_relative_deadline,
                                      burst: req_burst, remaining: '0,
                                      release_t: '0, lost: '0, complete: '0};
                        valid_in[IW'(req_task_index)] = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_LOAD;
                     rsp_task_in  = req_task_index;
                     rsp_ok_in    = load_ok;
                     rsp_last_in  = 1'b1;
                  end
                  OP_TICK: begin
                     i_in      = '0;
                     choice_in = CHOICE_IDLE;
                     best_in   = '0;
                     state_in  = (n_act == '0) ? S_T_CRD : S_T_RD;
                  end
                  OP_FINISH: begin
                     if (prev_ff == CHOICE_IDLE) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_IDLE;
                        rsp_len_in   = seg_ff;
                        rsp_last_in  = (n_act == '0);
                     end
                     i_in     = '0;
                     state_in = S_F_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_T_RD: begin
            mem_re   = 1'b1;
            state_in = S_T_DST;
         end
         S_T_DST: begin
            div_start = 1'b1;
            state_in  = S_T_DIV;
         end
         S_T_DIV: begin
            if (div_done) begin
               state_in = S_T_WR;
            end
         end
         S_T_WR: begin
            if (rd_valid_ff) begin
               mem_we = 1'b1;
               mem_wd = e;
               mem_wd.remaining = rw2;
               mem_wd.release_t = rt1;
               mem_wd.lost      = lost2;
            end
            // Strict compare keeps the lowest index on equal keys.
            if (rw2 != '0 && (choice_ff == CHOICE_IDLE || key < best_ff)) begin
               choice_in = CHOICE_W'(i_ff);
               best_in   = key;
            end
            i_in     = i_ff + 1'b1;
            state_in = (i_ff + 1'b1 < n_act) ? S_T_RD : S_T_CRD;
         end
         S_T_CRD: begin
            if (choice_ff != CHOICE_IDLE) begin
               mem_re   = 1'b1;
               mem_ra   = IW'(choice_ff);
               state_in = S_T_CWR;
            end else begin
               state_in = S_T_PRD;
            end
         end
         S_T_CWR: begin
            mem_we = 1'b1;
            mem_wa = IW'(choice_ff);
            mem_wd = e;
            mem_wd.remaining = dec;
            if (dec == '0 && e.complete != CNT_MAX) begin
               mem_wd.complete = e.complete + 1'b1;
            end
            state_in = S_T_PRD;
         end
         S_T_PRD: begin
            if (prev_is_task) begin
               mem_re = 1'b1;
               mem_ra = IW'(prev_ff);
            end
            state_in = S_T_REP;
         end
         S_T_REP: begin
            if (prev_ff == choice_ff) begin
               if (seg_ff != SEG_MAX) begin
                  seg_in = seg_ff + 1'b1;
               end
            end else begin
               if (prev_ff == CHOICE_IDLE) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_IDLE;
                  rsp_len_in   = seg_ff;
                  rsp_last_in  = 1'b1;
               end else if (prev_is_task) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_TASK;
                  rsp_task_in  = prev_ff[3:0];
                  rsp_len_in   = seg_ff;
                  rsp_last_in  = 1'b1;
                  // The entry read here already holds this tick's release time,
                  // so the deadline test works on the stored values directly.
                  if (TIME_BITS'(KW'(e.release_t) + KW'(e.deadline)) == time_ff) begin
                     rsp_reason_in = REASON_LOST;
                  end else if (e.remaining == '0) begin
                     rsp_reason_in = REASON_FINISH;
                  end else begin
                     rsp_reason_in = REASON_PREEMPT;
                  end
               end
               seg_in = SEG_W'(1);
            end
            prev_in  = choice_ff;
            time_in  = time_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_F_RD: begin
            if (i_ff < n_act) begin
               mem_re   = 1'b1;
               state_in = S_F_EM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_F_EM: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_STATS;
            rsp_task_in   = i_ff[3:0];
            rsp_lost_in   = e.lost;
            rsp_comp_in   = e.complete;
            rsp_killed_in = (e.remaining != '0);
            rsp_last_in   = (i_ff + 1'b1 == n_act);
            i_in          = i_ff + 1'b1;
            state_in      = S_F_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= 1'b0;
         count_ff     <= '0;
         i_ff         <= '0;
         choice_ff    <= CHOICE_IDLE;
         prev_ff      <= CHOICE_NONE;
         best_ff      <= '0;
         time_ff      <= '0;
         seg_ff       <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         choice_ff    <= choice_in;
         prev_ff      <= prev_in;
         best_ff      <= best_in;
         time_ff      <= time_in;
         seg_ff       <= seg_in;
         valid_ff     <= valid_in;
         if (mem_re) begin
            rd_valid_ff <= valid_ff[mem_ra];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_reason_ff <= rsp_reason_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_lost_ff   <= rsp_lost_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_killed_ff <= rsp_killed_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_which_task     = rsp_task_ff;
   assign rsp_run_length     = rsp_len_ff;
   assign rsp_end_reason     = rsp_reason_ff;
   assign rsp_load_ok        = rsp_ok_ff;
   assign rsp_lost_total     = rsp_lost_ff;
   assign rsp_complete_total = rsp_comp_ff;
   assign rsp_killed_total   = rsp_killed_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
`default_nettype wire
